// File: rtl/core/tfbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbs_pkg
// Shared types and constants of the text frame buffer serializer: command
// codes, refresh stream bytes, controller states and the glyph font.
// ----------------------------------------------------------------------------
package tfbs_pkg;

    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_PUT   = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    localparam logic [7:0] BUS_ADDRESS_RESET = 8'h78;
    localparam logic [7:0] CTRL_CMD          = 8'h00;
    localparam logic [7:0] CTRL_DATA         = 8'h40;
    localparam logic [7:0] CMD_PAGE_BASE     = 8'hB0;
    localparam logic [7:0] CMD_COL_LOW       = 8'h00;
    localparam logic [7:0] CMD_COL_HIGH      = 8'h10;

    localparam int GLYPH_COUNT = 17;
    localparam int GLYPH_WIDTH = 6;
    localparam logic [4:0] GLYPH_BLANK = 5'd12;

    typedef logic [4:0] glyph_idx_t;
    typedef logic [2:0] glyph_col_t;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_PUT   = 5'b00100,
        ST_READ  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    localparam logic [7:0] GLYPHS [GLYPH_COUNT][GLYPH_WIDTH] = '{
        '{8'h00, 8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E},
        '{8'h00, 8'h00, 8'h42, 8'h7F, 8'h40, 8'h00},
        '{8'h00, 8'h62, 8'h51, 8'h49, 8'h49, 8'h46},
        '{8'h00, 8'h22, 8'h41, 8'h49, 8'h49, 8'h36},
        '{8'h00, 8'h18, 8'h14, 8'h12, 8'h7F, 8'h10},
        '{8'h00, 8'h27, 8'h45, 8'h45, 8'h45, 8'h39},
        '{8'h00, 8'h3E, 8'h49, 8'h49, 8'h49, 8'h32},
        '{8'h00, 8'h01, 8'h71, 8'h09, 8'h05, 8'h03},
        '{8'h00, 8'h36, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h00, 8'h06, 8'h49, 8'h49, 8'h49, 8'h3E},
        '{8'h00, 8'h02, 8'h0C, 8'h30, 8'h0C, 8'h02},
        '{8'h00, 8'h00, 8'h80, 8'h60, 8'h00, 8'h00},
        '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h00, 8'h08, 8'h08, 8'h08, 8'h08, 8'h08},
        '{8'h00, 8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
        '{8'h00, 8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
        '{8'h00, 8'h01, 8'h01, 8'h7F, 8'h01, 8'h01}
    };

    // ascii code to font entry, anything outside the font is blank
    function automatic glyph_idx_t glyph_of(input logic [7:0] code);
        glyph_idx_t idx;
        begin
            idx = GLYPH_BLANK;
            if (code >= 8'h30 && code <= 8'h39)
            begin
                idx = glyph_idx_t'(code - 8'h30);
            end
            else
            begin
                case (code)
                    8'h56:   idx = 5'd10;
                    8'h2E:   idx = 5'd11;
                    8'h20:   idx = 5'd12;
                    8'h2D:   idx = 5'd13;
                    8'h42:   idx = 5'd14;
                    8'h41:   idx = 5'd15;
                    8'h54:   idx = 5'd16;
                    default: idx = GLYPH_BLANK;
                endcase
            end
            return idx;
        end
    endfunction

endpackage

// File: rtl/core/tfbs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbs_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module tfbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/text_frame_buffer_serializer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_frame_buffer_serializer_unit
// Page-organized monochrome frame buffer with character drawing and a
// byte-level refresh stream serializer for a page-addressed display.
//
//   channel   direction  tdata                          tuser
//   s_*       in         x_pos, y_pos, char_code        command
//   m_*       out        bus_byte (tlast = frame_done)  start_before, stop_after
//   apb       in/out     register 0 at 0x0: bus_address
//
// clear: the accepting cycle and then one ram entry per cycle; the same
// pass runs after reset before the first item
// put character: accepting cycle plus one glyph column per cycle; nothing
// is written when the position is rejected
// flush step: accept, ram read, emit; emit waits while a byte is held and m_tready is low
// other command codes: accepted, no result
// ----------------------------------------------------------------------------
module text_frame_buffer_serializer_unit #(
    parameter int PAGE_COUNT   = 8,
    parameter int COLUMN_COUNT = 128
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // x_pos[7:0], y_pos[15:8], char_code[23:16]
    input  logic [1:0]  s_tuser,   // command[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // bus_byte[7:0]
    output logic [1:0]  m_tuser,   // start_before[0], stop_after[1]
    output logic        m_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int DEPTH    = PAGE_COUNT * COLUMN_COUNT;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PAGE_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int PAGE_LEN = COLUMN_COUNT + 11;
    localparam int OFF_W    = $clog2(PAGE_LEN);
    localparam int OFF_LAST = PAGE_LEN - 1;

    tfbs_pkg::state_t state_reg, state_next;

    logic [7:0]            bus_address_reg;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;
    logic [ADDR_W-1:0]     put_addr_reg, put_addr_next;
    tfbs_pkg::glyph_col_t  step_reg, step_next;
    tfbs_pkg::glyph_idx_t  glyph_reg, glyph_next;
    logic [PAGE_W-1:0]     page_reg, page_next;
    logic [OFF_W-1:0]      off_reg, off_next;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_data_reg;
    logic [1:0] out_user_reg;
    logic       out_last_reg;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [7:0]        ram_rdata;

    logic       in_fire;
    logic       out_free;
    logic       emit_load;
    logic [7:0] in_x;
    logic [7:0] in_y;
    logic [7:0] in_char;
    logic       put_ok;
    logic       frame_last;
    logic       off_last;
    logic [7:0] emit_byte;
    logic       emit_start;
    logic       emit_stop;
    logic       cfg_write;

    assign in_x    = s_tdata[7:0];
    assign in_y    = s_tdata[15:8];
    assign in_char = s_tdata[23:16];

    assign s_tready = (state_reg == tfbs_pkg::ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign emit_load = (state_reg == tfbs_pkg::ST_EMIT) && out_free;

    assign put_ok = (in_y[2:0] == 3'd0)
                 && (32'(in_y[7:3]) < PAGE_COUNT)
                 && ((10'(in_x) + 10'd7) <= 10'(COLUMN_COUNT));

    assign off_last   = (off_reg == OFF_W'(OFF_LAST));
    assign frame_last = off_last && (page_reg == PAGE_W'(PAGE_COUNT - 1));

    // data byte address for the current stream position
    assign ram_raddr = ADDR_W'(32'(page_reg) * COLUMN_COUNT + 32'(off_reg) - 32'd11);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = put_addr_reg;
        ram_wdata = tfbs_pkg::GLYPHS[glyph_reg][step_reg];
        case (state_reg)
            tfbs_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = 8'h00;
            end
            tfbs_pkg::ST_PUT:
            begin
                ram_we = 1'b1;
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    tfbs_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // refresh stream byte at the current position
    always_comb
    begin
        emit_byte  = ram_rdata;
        emit_start = 1'b0;
        emit_stop  = 1'b0;
        case (off_reg)
            OFF_W'(0), OFF_W'(3), OFF_W'(6), OFF_W'(9):
            begin
                emit_byte  = bus_address_reg;
                emit_start = 1'b1;
            end
            OFF_W'(1), OFF_W'(4), OFF_W'(7):
            begin
                emit_byte = tfbs_pkg::CTRL_CMD;
            end
            OFF_W'(2):
            begin
                emit_byte = tfbs_pkg::CMD_PAGE_BASE + 8'(page_reg);
                emit_stop = 1'b1;
            end
            OFF_W'(5):
            begin
                emit_byte = tfbs_pkg::CMD_COL_LOW;
                emit_stop = 1'b1;
            end
            OFF_W'(8):
            begin
                emit_byte = tfbs_pkg::CMD_COL_HIGH;
                emit_stop = 1'b1;
            end
            OFF_W'(10):
            begin
                emit_byte = tfbs_pkg::CTRL_DATA;
            end
            default:
            begin
                emit_byte = ram_rdata;
                emit_stop = off_last;
            end
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        put_addr_next = put_addr_reg;
        step_next     = step_reg;
        glyph_next    = glyph_reg;
        page_next     = page_reg;
        off_next      = off_reg;
        case (state_reg)
            tfbs_pkg::ST_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = tfbs_pkg::ST_IDLE;
                end
            end
            tfbs_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (s_tuser)
                        tfbs_pkg::CMD_CLEAR:
                        begin
                            clr_addr_next = '0;
                            state_next    = tfbs_pkg::ST_CLEAR;
                        end
                        tfbs_pkg::CMD_PUT:
                        begin
                            put_addr_next = ADDR_W'(32'(in_y[7:3]) * COLUMN_COUNT
                                                    + 32'(in_x));
                            glyph_next    = tfbs_pkg::glyph_of(in_char);
                            step_next     = '0;
                            if (put_ok)
                            begin
                                state_next = tfbs_pkg::ST_PUT;
                            end
                        end
                        tfbs_pkg::CMD_FLUSH:
                        begin
                            state_next = tfbs_pkg::ST_READ;
                        end
                        default:
                        begin
                            state_next = tfbs_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            tfbs_pkg::ST_PUT:
            begin
                put_addr_next = put_addr_reg + 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == 3'(tfbs_pkg::GLYPH_WIDTH - 1))
                begin
                    state_next = tfbs_pkg::ST_IDLE;
                end
            end
            tfbs_pkg::ST_READ:
            begin
                state_next = tfbs_pkg::ST_EMIT;
            end
            tfbs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = tfbs_pkg::ST_IDLE;
                    if (off_last)
                    begin
                        off_next  = '0;
                        page_next = frame_last ? '0 : page_reg + 1'b1;
                    end
                    else
                    begin
                        off_next = off_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = tfbs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfbs_pkg::ST_CLEAR;
            clr_addr_reg  <= '0;
            page_reg      <= '0;
            off_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            page_reg      <= page_next;
            off_reg       <= off_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        put_addr_reg <= put_addr_next;
        step_reg     <= step_next;
        glyph_reg    <= glyph_next;
        if (emit_load)
        begin
            out_data_reg <= emit_byte;
            out_user_reg <= {emit_stop, emit_start};
            out_last_reg <= frame_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // configuration port
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == 1'b0) ? {24'h000000, bus_address_reg} : 32'h0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_address_reg <= tfbs_pkg::BUS_ADDRESS_RESET;
        end
        else if (cfg_write)
        begin
            bus_address_reg <= pwdata[7:0];
        end
    end

endmodule

// File: rtl/core/tfbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfbs_checker
// Port-level checks of the text frame buffer serializer, bound to the top.
// ----------------------------------------------------------------------------
module tfbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic [1:0] s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // input side closed right after reset, at the start of the post-reset clearing pass
    a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $past(!rst_n) |-> !s_tready)
        else $error("input ready during post-reset clearing pass");

    // clear and flush drop input ready in the cycle after they are accepted
    a_busy_after_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready
            && (s_tuser == tfbs_pkg::CMD_CLEAR || s_tuser == tfbs_pkg::CMD_FLUSH)
            |=> !s_tready)
        else $error("input ready right after accepting a command");

    // frame end closes a transaction
    a_frame_end_stop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser[1] && !m_tuser[0])
        else $error("frame end item without stop");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tuser) && $stable(m_tlast))
        else $error("stalled output item changed");

endmodule

bind text_frame_buffer_serializer_unit tfbs_checker u_tfbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// File: test/text_frame_buffer_serializer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_frame_buffer_serializer_unit_tb
// Drives clear, character, refresh and no-op commands into the frame buffer while
// the output side stalls on its own pattern. A scoreboard keeps a shadow copy
// of the page store, the stream position and the bus address. It predicts
// every refresh byte with its start, stop and frame end marks, and it checks
// each byte taken from the output stream against that prediction. The bus
// address register is rewritten between phases, the extreme values included.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [7:0] bus_byte;
    logic       start_before;
    logic       stop_after;
    logic       frame_done;
} refresh_byte_t;

class refresh_scoreboard;

    localparam int PAGES      = 8;
    localparam int COLUMNS    = 128;
    localparam int PAGE_BYTES = 11 + COLUMNS;
    localparam int FRAME_LEN  = PAGES * PAGE_BYTES;

    logic [7:0]    pixel_pages [PAGES][COLUMNS];
    int unsigned   stream_pos;
    logic [7:0]    bus_addr;
    refresh_byte_t expected_bytes [$];
    int unsigned   mismatches;
    int unsigned   refresh_bytes;
    int unsigned   drawn_chars;
    int unsigned   rejected_chars;
    int unsigned   clears;
    int unsigned   frames;

    function new();
        clear_pages();
        stream_pos     = 0;
        bus_addr       = tfbs_pkg::BUS_ADDRESS_RESET;
        mismatches     = 0;
        refresh_bytes  = 0;
        drawn_chars    = 0;
        rejected_chars = 0;
        clears         = 0;
        frames         = 0;
    endfunction

    function void clear_pages();
        foreach (pixel_pages[p, c])
        begin
            pixel_pages[p][c] = 8'h00;
        end
    endfunction

    // six column bytes, leftmost column in the top bits
    function logic [47:0] glyph_bits(logic [7:0] code);
        logic [47:0] g;
        case (code)
            8'h30:   g = 48'h00_3E_51_49_45_3E;
            8'h31:   g = 48'h00_00_42_7F_40_00;
            8'h32:   g = 48'h00_62_51_49_49_46;
            8'h33:   g = 48'h00_22_41_49_49_36;
            8'h34:   g = 48'h00_18_14_12_7F_10;
            8'h35:   g = 48'h00_27_45_45_45_39;
            8'h36:   g = 48'h00_3E_49_49_49_32;
            8'h37:   g = 48'h00_01_71_09_05_03;
            8'h38:   g = 48'h00_36_49_49_49_36;
            8'h39:   g = 48'h00_06_49_49_49_3E;
            8'h56:   g = 48'h00_02_0C_30_0C_02;
            8'h2E:   g = 48'h00_00_80_60_00_00;
            8'h2D:   g = 48'h00_08_08_08_08_08;
            8'h42:   g = 48'h00_7F_49_49_49_36;
            8'h41:   g = 48'h00_7F_09_09_09_06;
            8'h54:   g = 48'h00_01_01_7F_01_01;
            default: g = 48'h0;
        endcase
        return g;
    endfunction

    function void draw_char(logic [7:0] x, logic [7:0] y, logic [7:0] code);
        logic [47:0] g;
        int          page;
        g    = glyph_bits(code);
        page = int'(y) / 8;
        if (y[2:0] != 3'd0 || page >= PAGES || int'(x) + 7 > COLUMNS)
        begin
            rejected_chars++;
            return;
        end
        for (int i = 0; i < 6; i++)
        begin
            pixel_pages[page][int'(x) + i] = g[(5 - i) * 8 +: 8];
        end
        drawn_chars++;
    endfunction

    function refresh_byte_t next_refresh_byte();
        refresh_byte_t r;
        int            page;
        int            off;
        int            col;
        r    = '0;
        page = stream_pos / PAGE_BYTES;
        off  = stream_pos % PAGE_BYTES;
        if (off < 9)
        begin
            if (off % 3 == 0)
            begin
                r.bus_byte     = bus_addr;
                r.start_before = 1'b1;
            end
            else if (off % 3 == 1)
            begin
                r.bus_byte = tfbs_pkg::CTRL_CMD;
            end
            else
            begin
                r.stop_after = 1'b1;
                if (off / 3 == 0)
                    r.bus_byte = tfbs_pkg::CMD_PAGE_BASE + 8'(page);
                else if (off / 3 == 1)
                    r.bus_byte = tfbs_pkg::CMD_COL_LOW;
                else
                    r.bus_byte = tfbs_pkg::CMD_COL_HIGH;
            end
        end
        else if (off == 9)
        begin
            r.bus_byte     = bus_addr;
            r.start_before = 1'b1;
        end
        else if (off == 10)
        begin
            r.bus_byte = tfbs_pkg::CTRL_DATA;
        end
        else
        begin
            col          = off - 11;
            r.bus_byte   = pixel_pages[page][col];
            r.stop_after = (col == COLUMNS - 1);
        end
        stream_pos++;
        if (stream_pos >= FRAME_LEN)
        begin
            stream_pos   = 0;
            r.frame_done = 1'b1;
            frames++;
        end
        return r;
    endfunction

    function void note_item(logic [1:0] cmd, logic [7:0] x, logic [7:0] y,
                            logic [7:0] code);
        case (cmd)
            tfbs_pkg::CMD_CLEAR:
            begin
                clear_pages();
                clears++;
            end
            tfbs_pkg::CMD_PUT:
            begin
                draw_char(x, y, code);
            end
            tfbs_pkg::CMD_FLUSH:
            begin
                expected_bytes.push_back(next_refresh_byte());
                refresh_bytes++;
            end
            default:
            begin
            end
        endcase
    endfunction

    function int unsigned pending();
        return expected_bytes.size();
    endfunction

    task report(string msg);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch: %s", msg);
    endtask

    task check_result(logic [7:0] data, logic [1:0] user, logic last);
        refresh_byte_t e;
        if (expected_bytes.size() == 0)
        begin
            report($sformatf("byte %02h arrived with nothing expected", data));
            return;
        end
        e = expected_bytes.pop_front();
        if (data !== e.bus_byte)
            report($sformatf("bus byte %02h, expected %02h", data, e.bus_byte));
        if (user[0] !== e.start_before)
            report($sformatf("start mark %b, expected %b on byte %02h",
                             user[0], e.start_before, e.bus_byte));
        if (user[1] !== e.stop_after)
            report($sformatf("stop mark %b, expected %b on byte %02h",
                             user[1], e.stop_after, e.bus_byte));
        if (last !== e.frame_done)
            report($sformatf("frame end %b, expected %b on byte %02h",
                             last, e.frame_done, e.bus_byte));
    endtask

endclass

module text_frame_buffer_serializer_unit_tb;

    localparam int          WATCHDOG_LIMIT  = 20000;
    localparam int          SETTLE_CYCLES   = 1100;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          PHASE_ITEMS     = 450;
    localparam logic [2:0]  REG_BUS_ADDRESS = 3'd0;
    localparam logic [7:0]  FONT_CODES [17] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h56, 8'h2E, 8'h20, 8'h2D, 8'h42, 8'h41, 8'h54
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = tfbs_pkg::CMD_CLEAR;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    refresh_scoreboard sb;

    int unsigned burst_left     = 0;
    int unsigned items_sent     = 0;
    int unsigned addr_settings  = 0;
    int unsigned hold_req       = 0;
    int unsigned hold_seen      = 0;
    int unsigned hold_left      = 0;
    int unsigned rx_mode        = 0;
    int unsigned rx_left        = 0;
    int unsigned rx_phase       = 0;
    int unsigned idle_cycles    = 0;

    text_frame_buffer_serializer_unit uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #2 clk = ~clk;

    // output side: check taken bytes, then pick the next ready value
    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tuser, m_tlast);
        rx_phase++;
        if (hold_seen != hold_req)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(32, 256);
            end
            else
            begin
                rx_left--;
            end
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= ($urandom_range(0, 3) != 0);
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= rx_phase[2];
            endcase
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    task send_item(input logic [1:0] cmd, input logic [7:0] x, input logic [7:0] y,
                   input logic [7:0] code);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {code, y, x};
        do @(posedge clk); while (!s_tready);
        sb.note_item(cmd, x, y, code);
        items_sent++;
    endtask

    task random_item();
        int unsigned r;
        logic [1:0]  cmd;
        logic [7:0]  x;
        logic [7:0]  y;
        logic [7:0]  code;
        r    = $urandom_range(0, 999);
        x    = 8'($urandom);
        y    = 8'($urandom);
        code = 8'($urandom);
        if (r < 700)
        begin
            cmd = tfbs_pkg::CMD_FLUSH;
        end
        else if (r < 950)
        begin
            cmd = tfbs_pkg::CMD_PUT;
            if ($urandom_range(0, 4) != 0)
            begin
                x    = 8'($urandom_range(0, 121));
                y    = 8'($urandom_range(0, 7)) << 3;
                code = FONT_CODES[$urandom_range(0, 16)];
            end
            else if ($urandom_range(0, 1) == 0)
            begin
                // near the edges of the accepted range
                x = 8'($urandom_range(119, 124));
                y = 8'($urandom_range(54, 66));
            end
        end
        else if (r < 990)
        begin
            cmd = tfbs_pkg::CMD_NOP;
        end
        else
        begin
            cmd = tfbs_pkg::CMD_CLEAR;
        end
        send_item(cmd, x, y, code);
    endtask

    task reg_write(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task reg_read_check(input logic [2:0] addr, input logic [31:0] expected);
        logic [31:0] got;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== expected)
            sb.report($sformatf("register read %08h, expected %08h", got, expected));
    endtask

    // wait for the block to go idle, then change the bus address
    task set_bus_address(input logic [7:0] value);
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        reg_write(REG_BUS_ADDRESS, {24'h0, value});
        sb.bus_addr = value;
        addr_settings++;
        reg_read_check(REG_BUS_ADDRESS, {24'h0, value});
    endtask

    initial
    begin
        logic [7:0] phase_addr [4];
        sb = new();
        phase_addr[0] = 8'h00;
        phase_addr[1] = 8'hFF;
        phase_addr[2] = 8'($urandom);
        phase_addr[3] = 8'h5A;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        reg_read_check(REG_BUS_ADDRESS, {24'h0, tfbs_pkg::BUS_ADDRESS_RESET});

        // directed: edges of the drawing window, most glyphs, all commands
        send_item(tfbs_pkg::CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        send_item(tfbs_pkg::CMD_PUT,   8'd0,   8'd0,   8'h30);
        send_item(tfbs_pkg::CMD_PUT,   8'd121, 8'd56,  8'h54);
        send_item(tfbs_pkg::CMD_PUT,   8'd122, 8'd0,   8'h41);
        send_item(tfbs_pkg::CMD_PUT,   8'd255, 8'd255, 8'h42);
        send_item(tfbs_pkg::CMD_PUT,   8'd10,  8'd3,   8'h35);
        send_item(tfbs_pkg::CMD_PUT,   8'd10,  8'd64,  8'h56);
        send_item(tfbs_pkg::CMD_PUT,   8'd20,  8'd8,   8'h39);
        send_item(tfbs_pkg::CMD_PUT,   8'd22,  8'd8,   8'hFF);
        send_item(tfbs_pkg::CMD_PUT,   8'd60,  8'd8,   8'h00);
        send_item(tfbs_pkg::CMD_PUT,   8'd30,  8'd16,  8'h2E);
        send_item(tfbs_pkg::CMD_PUT,   8'd40,  8'd24,  8'h2D);
        send_item(tfbs_pkg::CMD_PUT,   8'd3,   8'd0,   8'h20);
        send_item(tfbs_pkg::CMD_PUT,   8'd50,  8'd32,  8'h34);
        send_item(tfbs_pkg::CMD_NOP,   8'hFF,  8'hFF,  8'hFF);
        send_item(tfbs_pkg::CMD_NOP,   8'h00,  8'h00,  8'h00);
        for (int i = 0; i < 6; i++)
        begin
            if (i[0])
                send_item(tfbs_pkg::CMD_FLUSH, 8'hFF, 8'hFF, 8'hFF);
            else
                send_item(tfbs_pkg::CMD_FLUSH, 8'h00, 8'h00, 8'h00);
        end
        send_item(tfbs_pkg::CMD_CLEAR, 8'hFF, 8'hFF, 8'hFF);
        send_item(tfbs_pkg::CMD_PUT,   8'd0,   8'd0,   8'h38);
        send_item(tfbs_pkg::CMD_FLUSH, 8'h00, 8'h00, 8'h00);

        for (int ph = 0; ph < 4; ph++)
        begin
            set_bus_address(phase_addr[ph]);
            if (ph == 1)
                hold_req <= hold_req + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_item();
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);

        $display("run covered %0d items: %0d refresh bytes over %0d full frames",
                 items_sent, sb.refresh_bytes, sb.frames);
        $display("%0d glyphs drawn, %0d rejected, %0d clears, %0d address settings",
                 sb.drawn_chars, sb.rejected_chars, sb.clears, addr_settings);
        if (sb.mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
